@@ rtl/b3mf_pkg.sv @@
package b3mf_pkg;

  localparam int REG_W          = 13;
  localparam int ROW_W          = 13;
  localparam int DATA_W         = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int RESET_WIDTH    = 640;
  localparam int RESET_HEIGHT   = 480;
  localparam int ROUND_BIAS     = 4;
  localparam int TAP_COUNT      = 9;
  localparam int OUT_DEPTH      = 8;
  localparam int PTR_W          = $clog2(OUT_DEPTH);
  localparam int OCC_W          = $clog2(OUT_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef struct packed {
    logic              last;
    logic [DATA_W-1:0] mean;
  } res_t;

endpackage

@@ rtl/b3mf_mean_div.sv @@
module b3mf_mean_div #(
  parameter int PIXEL_BITS = b3mf_pkg::DEF_PIXEL_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_vld_i,
  input  logic                  in_last_i,
  input  logic [PIXEL_BITS+1:0] sum_l_i,
  input  logic [PIXEL_BITS+1:0] sum_c_i,
  input  logic [PIXEL_BITS+1:0] sum_r_i,
  output logic                  out_vld_o,
  output b3mf_pkg::res_t        out_res_o
);

  localparam int SUM_W  = PIXEL_BITS + 4;
  localparam int SHIFT  = SUM_W + 3;
  localparam int PROD_W = 2 * SUM_W;
  // ceil(2^SHIFT / 9): exact quotient for every sum below 2^SUM_W
  localparam int RECIP  = ((1 << SHIFT) + b3mf_pkg::TAP_COUNT - 1) / b3mf_pkg::TAP_COUNT;

  logic              tot_vld_q, prod_vld_q;
  logic              tot_last_q, prod_last_q;
  logic [SUM_W-1:0]  tot_q;
  logic [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      tot_vld_q  <= in_vld_i;
      prod_vld_q <= tot_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tot_q       <= SUM_W'(sum_l_i) + SUM_W'(sum_c_i) + SUM_W'(sum_r_i)
                 + SUM_W'(b3mf_pkg::ROUND_BIAS);
    tot_last_q  <= in_last_i;
    prod_q      <= PROD_W'(tot_q) * PROD_W'(RECIP);
    prod_last_q <= tot_last_q;
  end

  assign out_vld_o      = prod_vld_q;
  assign out_res_o.mean = b3mf_pkg::DATA_W'(prod_q[SHIFT +: PIXEL_BITS]);
  assign out_res_o.last = prod_last_q;

endmodule

@@ rtl/b3mf_out_fifo.sv @@
module b3mf_out_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b3mf_pkg::res_t push_res_i,
  output logic           pop_vld_o,
  input  logic           pop_rdy_i,
  output b3mf_pkg::res_t pop_res_o
);

  b3mf_pkg::res_t                 slot_q [b3mf_pkg::OUT_DEPTH];
  logic [b3mf_pkg::PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [b3mf_pkg::PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [b3mf_pkg::OCC_W-1:0]     cnt_q, cnt_d;
  logic                           pop;

  assign pop_vld_o = (cnt_q != '0);
  assign pop       = pop_vld_o && pop_rdy_i;
  assign pop_res_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + b3mf_pkg::PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + b3mf_pkg::PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + b3mf_pkg::OCC_W'(push_i) - b3mf_pkg::OCC_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_res_i;
    end
  end

endmodule

@@ rtl/box3x3_mean_filter.sv @@
// Result path: tap stage, column sum stage, divider total and product registers, output queue.
// Throughput: one beat per cycle while the output queue has room, set by the single
// read-modify-write of the line store per column; a drain beat on a one-row frame waits once.
// Reset clears counters, pipeline valids and the output queue and loads 640x480; the line
// store is not cleared, an entry is always written before it can reach a result.
module box3x3_mean_filter #(
  parameter int MAX_WIDTH  = b3mf_pkg::DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = b3mf_pkg::DEF_PIXEL_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [b3mf_pkg::REG_W-1:0]  cfg_data_i,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [b3mf_pkg::DATA_W-1:0] s_axis_tdata_i,  // pixel_in
  input  logic                        s_axis_tuser_i,  // command
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [b3mf_pkg::DATA_W-1:0] m_axis_tdata_o,  // mean_out
  output logic                        m_axis_tlast_o   // frame_last
);

  localparam int P     = PIXEL_BITS;
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int SW    = P + 2;
  localparam int RW    = b3mf_pkg::ROW_W;
  localparam int W_RST = (b3mf_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                               : b3mf_pkg::RESET_WIDTH;

  function automatic logic [SW-1:0] colsum(input logic [P-1:0] a0, input logic [P-1:0] a1,
                                           input logic [P-1:0] a2, input logic top0,
                                           input logic bot);
    logic [P-1:0] t;
    logic [P-1:0] bt;
    t  = top0 ? a1 : a0;
    bt = bot ? a1 : a2;
    return SW'(t) + SW'(a1) + SW'(bt);
  endfunction

  // configuration and frame position
  logic [WW-1:0]             w_q, w_d, w_eff;
  logic [RW-1:0]             h_q, h_d, h_eff;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [PW-1:0]             pend_q, pend_d, pend_base;
  logic [b3mf_pkg::OCC_W-1:0] occ_q, occ_d;
  logic [31:0]               cfg_wide;

  // issue stage
  logic          is_pix, frame_done, drain_live, restart;
  logic [CW-1:0] ix;
  logic [RW-1:0] iy;
  logic          emit_a, emit_b, emits, skip, acc, do_visit_acc, visit, emit_acc, m_acc;
  logic [WW-1:0] col_inc;
  logic          wrap;

  // line store: {upper, middle} per column
  logic [2*P-1:0] line_mem [MAX_WIDTH];
  logic [2*P-1:0] mem_rd_q;

  // tap stage
  logic           s1_vld_q, s1_real_q, s1_emit_q, s1_ea_q, s1_lsel_q;
  logic           s1_top_q, s1_bot_q, s1_last_q;
  logic [P-1:0]   s1_pix_q;
  logic [CW-1:0]  s1_addr_q;
  logic           fwd_q;
  logic [2*P-1:0] fwd_data_q;
  logic [2*P-1:0] s1_line;
  logic [P-1:0]   s1_u, s1_m, s1_b;
  logic           s1_we;
  logic [P-1:0]   tap_q [3][3];
  logic [P-1:0]   nc   [3];
  logic [P-1:0]   lft  [3];
  logic [P-1:0]   rgt  [3];

  // column sum stage
  logic          s2_vld_q, s2_last_q;
  logic [SW-1:0] s2_sl_q, s2_sc_q, s2_sr_q;

  logic           div_vld;
  b3mf_pkg::res_t div_res;
  b3mf_pkg::res_t out_res;

  assign cfg_wide = 32'(cfg_data_i);

  always_comb begin
    if (cfg_data_i == '0) begin
      w_eff = WW'(1);
    end else if (cfg_wide > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      h_eff = RW'(1);
    end else if (cfg_data_i > b3mf_pkg::REG_W'(b3mf_pkg::MAX_HEIGHT)) begin
      h_eff = RW'(b3mf_pkg::MAX_HEIGHT);
    end else begin
      h_eff = RW'(cfg_data_i);
    end
  end

  always_comb begin
    is_pix       = (b3mf_pkg::cmd_e'(s_axis_tuser_i) == b3mf_pkg::CMD_PIXEL);
    frame_done   = (row_q >= h_q);
    drain_live   = frame_done && (pend_q != '0);
    restart      = is_pix && frame_done;
    ix           = restart ? '0 : col_q;
    iy           = restart ? '0 : row_q;
    emit_a       = (ix == '0) && (iy >= RW'(2));
    emit_b       = (ix != '0) && (iy >= RW'(1));
    emits        = emit_a || emit_b;
    // a drain beat whose position yields nothing advances one column first
    skip         = s_axis_tvalid_i && !is_pix && drain_live && !emits;
    s_axis_tready_o = (occ_q < b3mf_pkg::OCC_W'(b3mf_pkg::OUT_DEPTH)) && !skip;
    acc          = s_axis_tvalid_i && s_axis_tready_o;
    do_visit_acc = acc && (is_pix || drain_live);
    visit        = skip || do_visit_acc;
    emit_acc     = do_visit_acc && emits;
    m_acc        = m_axis_tvalid_o && m_axis_tready_i;
    col_inc      = WW'(ix) + WW'(1);
    wrap         = (col_inc == w_q);
    pend_base    = restart ? '0 : pend_q;
  end

  always_comb begin
    w_d    = w_q;
    h_d    = h_q;
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    occ_d  = occ_q + b3mf_pkg::OCC_W'(emit_acc) - b3mf_pkg::OCC_W'(m_acc);
    if (cfg_we_i) begin
      unique case (b3mf_pkg::cfg_reg_e'(cfg_idx_i))
        b3mf_pkg::REG_FRAME_WIDTH:  w_d = w_eff;
        b3mf_pkg::REG_FRAME_HEIGHT: h_d = h_eff;
        default: ;
      endcase
      col_d  = '0;
      row_d  = '0;
      pend_d = '0;
    end else begin
      if (visit) begin
        col_d = wrap ? '0 : CW'(col_inc);
        row_d = wrap ? iy + RW'(1) : iy;
      end
      if (acc && is_pix) begin
        pend_d = emits ? pend_base : pend_base + PW'(1);
      end else if (acc && drain_live) begin
        pend_d = pend_q - PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q      <= WW'(W_RST);
      h_q      <= RW'(b3mf_pkg::RESET_HEIGHT);
      col_q    <= '0;
      row_q    <= '0;
      pend_q   <= '0;
      occ_q    <= '0;
      s1_vld_q <= 1'b0;
      fwd_q    <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      w_q      <= w_d;
      h_q      <= h_d;
      col_q    <= col_d;
      row_q    <= row_d;
      pend_q   <= pend_d;
      occ_q    <= occ_d;
      s1_vld_q <= visit;
      fwd_q    <= visit && s1_we && (s1_addr_q == ix);
      s2_vld_q <= s1_vld_q && s1_emit_q;
    end
  end

  // line store read and write-back
  always_ff @(posedge clk_i) begin
    if (visit) begin
      mem_rd_q <= line_mem[ix];
    end
    if (s1_we) begin
      line_mem[s1_addr_q] <= {s1_m, s1_pix_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (visit) begin
      s1_real_q <= do_visit_acc && is_pix;
      s1_emit_q <= emits;
      s1_ea_q   <= emit_a;
      s1_lsel_q <= emit_a ? (w_q == WW'(1)) : (ix == CW'(1));
      s1_top_q  <= emit_a ? (iy == RW'(2)) : (iy == RW'(1));
      s1_bot_q  <= emit_a ? (iy > h_q) : (iy >= h_q);
      s1_last_q <= emit_a && (iy > h_q);
      s1_pix_q  <= s_axis_tdata_i[P-1:0];
      s1_addr_q <= ix;
    end
    fwd_data_q <= {s1_m, s1_pix_q};
  end

  always_comb begin
    s1_line = fwd_q ? fwd_data_q : mem_rd_q;
    s1_u    = s1_line[2*P-1:P];
    s1_m    = s1_line[P-1:0];
    s1_b    = s1_real_q ? s1_pix_q : s1_m;
    s1_we   = s1_vld_q && s1_real_q;
    nc[0]   = s1_u;
    nc[1]   = s1_m;
    nc[2]   = s1_b;
    for (int k = 0; k < 3; k++) begin
      lft[k] = s1_lsel_q ? tap_q[2][k] : tap_q[1][k];
      rgt[k] = s1_ea_q ? tap_q[2][k] : nc[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      for (int k = 0; k < 3; k++) begin
        tap_q[0][k] <= tap_q[1][k];
        tap_q[1][k] <= tap_q[2][k];
        tap_q[2][k] <= nc[k];
      end
      s2_sl_q   <= colsum(lft[0], lft[1], lft[2], s1_top_q, s1_bot_q);
      s2_sc_q   <= colsum(tap_q[2][0], tap_q[2][1], tap_q[2][2], s1_top_q, s1_bot_q);
      s2_sr_q   <= colsum(rgt[0], rgt[1], rgt[2], s1_top_q, s1_bot_q);
      s2_last_q <= s1_last_q;
    end
  end

  b3mf_mean_div #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_vld_i (s2_vld_q),
    .in_last_i(s2_last_q),
    .sum_l_i  (s2_sl_q),
    .sum_c_i  (s2_sc_q),
    .sum_r_i  (s2_sr_q),
    .out_vld_o(div_vld),
    .out_res_o(div_res)
  );

  b3mf_out_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (div_vld),
    .push_res_i(div_res),
    .pop_vld_o (m_axis_tvalid_o),
    .pop_rdy_i (m_axis_tready_i),
    .pop_res_o (out_res)
  );

  assign m_axis_tdata_o = out_res.mean;
  assign m_axis_tlast_o = out_res.last;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= b3mf_pkg::OCC_W'(b3mf_pkg::OUT_DEPTH))
    else $error("result credits exceed queue depth");

  a_skip_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip |=> !skip)
    else $error("drain beat skipped two positions");

  a_last_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_visit_acc && emit_a && (iy > h_q)) |=> (pend_q == '0))
    else $error("pending count not empty after final result");

  a_out_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (occ_q != '0))
    else $error("result beat without a credit");
`endif

endmodule

@@ dv/box3x3_mean_filter_tb.sv @@
module box3x3_mean_filter_tb;

  localparam int IDLE_GUARD   = 10;
  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_BEATS = 900;
  localparam int EDGE_BEATS   = 150;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_idx   = 1'b0;
  logic [b3mf_pkg::REG_W-1:0]  cfg_data  = '0;
  logic                        s_valid   = 1'b0;
  logic [b3mf_pkg::DATA_W-1:0] s_data    = '0;
  logic                        s_cmd     = 1'b0;
  logic                        m_ready   = 1'b0;
  logic                        s_tready;
  logic                        m_valid;
  logic [b3mf_pkg::DATA_W-1:0] m_data;
  logic                        m_last;

  box3x3_mean_filter u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_cmd),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last)
  );

  initial forever #1 clk = ~clk;

  // filter state as predicted
  logic [b3mf_pkg::DATA_W-1:0] row_above2 [b3mf_pkg::DEF_MAX_WIDTH];
  logic [b3mf_pkg::DATA_W-1:0] row_above1 [b3mf_pkg::DEF_MAX_WIDTH];
  logic [b3mf_pkg::DATA_W-1:0] win [3][3];  // [column][row], column 0 oldest
  int unsigned                 col_pos;
  int unsigned                 row_pos;
  int unsigned                 owed;
  logic [b3mf_pkg::REG_W-1:0]  cfg_width;
  logic [b3mf_pkg::REG_W-1:0]  cfg_height;
  b3mf_pkg::res_t              means_due [$];

  bit          idle_on = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet = 0;
  int unsigned errors = 0;
  int unsigned beats_sent = 0;
  int unsigned useful_beats = 0;
  int unsigned results_seen = 0;
  int unsigned random_frames = 0;

  function automatic int unsigned clamp_dim(logic [b3mf_pkg::REG_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return 32'(v);
  endfunction

  function automatic int unsigned frame_cols();
    return clamp_dim(cfg_width, b3mf_pkg::DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned frame_rows();
    return clamp_dim(cfg_height, b3mf_pkg::MAX_HEIGHT);
  endfunction

  function automatic void clear_frame();
    col_pos = 0;
    row_pos = 0;
    owed    = 0;
  endfunction

  // column sum with rows clamped into the frame
  function automatic int unsigned col_total(int c, int unsigned cy, int unsigned h);
    int unsigned top, mid, bot;
    mid = 32'(win[c][1]);
    top = (cy == 0) ? mid : 32'(win[c][0]);
    bot = (cy + 1 >= h) ? mid : 32'(win[c][2]);
    return top + mid + bot;
  endfunction

  function automatic b3mf_pkg::res_t window_mean(int lc, int cc, int rc, int unsigned cy,
                                                 int unsigned cx, int unsigned w,
                                                 int unsigned h);
    b3mf_pkg::res_t r;
    int unsigned    total;
    total  = col_total(lc, cy, h) + col_total(cc, cy, h) + col_total(rc, cy, h);
    r.mean = b3mf_pkg::DATA_W'((total + b3mf_pkg::ROUND_BIAS) / b3mf_pkg::TAP_COUNT);
    r.last = (cy + 1 == h) && (cx + 1 == w);
    return r;
  endfunction

  // one raster position; past the frame end a replicated column is fed
  function automatic bit advance_raster(logic [b3mf_pkg::DATA_W-1:0] pix, bit from_input,
                                        int unsigned w, int unsigned h,
                                        output b3mf_pkg::res_t r);
    int unsigned                 ix, iy;
    logic [b3mf_pkg::DATA_W-1:0] u, m, b;
    bit                          got;
    ix  = col_pos;
    iy  = row_pos;
    got = 1'b0;
    r   = '0;
    if (ix >= w) ix = 0;
    u = row_above2[ix];
    m = row_above1[ix];
    b = from_input ? pix : m;
    if (ix == 0 && iy >= 2) begin
      r   = window_mean((w == 1) ? 2 : 1, 2, 2, iy - 2, w - 1, w, h);
      got = 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      win[0][k] = win[1][k];
      win[1][k] = win[2][k];
    end
    win[2][0] = u;
    win[2][1] = m;
    win[2][2] = b;
    if (from_input) begin
      row_above2[ix] = m;
      row_above1[ix] = pix;
    end
    if (ix >= 1 && iy >= 1) begin
      r   = window_mean((ix == 1) ? 1 : 0, 1, 2, iy - 1, ix - 1, w, h);
      got = 1'b1;
    end
    col_pos = ix + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = iy + 1;
    end
    return got;
  endfunction

  function automatic bit box_mean_step(b3mf_pkg::cmd_e cmd, logic [b3mf_pkg::DATA_W-1:0] pix);
    int unsigned    w, h;
    b3mf_pkg::res_t r;
    bit             got;
    w   = frame_cols();
    h   = frame_rows();
    got = 1'b0;
    if (cmd == b3mf_pkg::CMD_PIXEL) begin
      if (row_pos >= h) clear_frame();
      got = advance_raster(pix, 1'b1, w, h, r);
      if (got) means_due.push_back(r);
      else owed++;
    end else if (row_pos >= h && owed != 0) begin
      for (int g = 0; g < 3 && !got; g++) begin
        got = advance_raster('0, 1'b0, w, h, r);
      end
      if (got) begin
        means_due.push_back(r);
        owed--;
      end
    end
    return got;
  endfunction

  task automatic send_beat(b3mf_pkg::cmd_e cmd, logic [b3mf_pkg::DATA_W-1:0] pix);
    bit got;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      s_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_valid = 1'b1;
    s_cmd   = cmd;
    s_data  = pix;
    do @(posedge clk); while (!s_tready);
    got = box_mean_step(cmd, pix);
    beats_sent++;
    if (cmd == b3mf_pkg::CMD_PIXEL || got) useful_beats++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    s_valid = 1'b0;
    while (means_due.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    hold_until_drained();
    repeat (IDLE_GUARD) @(posedge clk);
  endtask

  task automatic write_reg(b3mf_pkg::cfg_reg_e idx, logic [b3mf_pkg::REG_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == b3mf_pkg::REG_FRAME_WIDTH) cfg_width = val;
    else cfg_height = val;
    clear_frame();
  endtask

  task automatic stream_pixels(int unsigned n);
    repeat (n) send_beat(b3mf_pkg::CMD_PIXEL, b3mf_pkg::DATA_W'($urandom));
  endtask

  // drain ticks while the frame is complete and outputs are owed, then extra ones
  task automatic flush_frame(int unsigned max_flush, int unsigned extra);
    int unsigned k;
    k = 0;
    while (k < max_flush && row_pos >= frame_rows() && owed != 0) begin
      send_beat(b3mf_pkg::CMD_DRAIN, b3mf_pkg::DATA_W'($urandom));
      k++;
    end
    repeat (extra) send_beat(b3mf_pkg::CMD_DRAIN, b3mf_pkg::DATA_W'($urandom));
  endtask

  function automatic logic [b3mf_pkg::REG_W-1:0] pick_size(int unsigned common,
                                                           int unsigned wide);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r < 8) return b3mf_pkg::REG_W'($urandom_range(1, common));
    return b3mf_pkg::REG_W'($urandom_range(common + 1, wide));
  endfunction

  task automatic test_degenerate_sizes();
    write_reg(b3mf_pkg::REG_FRAME_WIDTH, '0);
    write_reg(b3mf_pkg::REG_FRAME_HEIGHT, '0);
    send_beat(b3mf_pkg::CMD_DRAIN, '1);  // nothing owed
    send_beat(b3mf_pkg::CMD_PIXEL, '1);
    send_beat(b3mf_pkg::CMD_DRAIN, '0);
    send_beat(b3mf_pkg::CMD_DRAIN, '1);  // already flushed
    send_beat(b3mf_pkg::CMD_PIXEL, '0);  // next frame
    send_beat(b3mf_pkg::CMD_DRAIN, '0);
  endtask

  task automatic test_checkerboard_3x3();
    write_reg(b3mf_pkg::REG_FRAME_WIDTH, b3mf_pkg::REG_W'(3));
    write_reg(b3mf_pkg::REG_FRAME_HEIGHT, b3mf_pkg::REG_W'(3));
    for (int i = 0; i < 9; i++) begin
      send_beat(b3mf_pkg::CMD_PIXEL, (i % 2) ? '1 : '0);
      if (i == 4) send_beat(b3mf_pkg::CMD_DRAIN, '1);  // frame still open
    end
    flush_frame(1, 0);
    send_beat(b3mf_pkg::CMD_PIXEL, '1);  // new frame drops what is still owed
    send_beat(b3mf_pkg::CMD_PIXEL, '0);
  endtask

  task automatic test_register_restart();
    write_reg(b3mf_pkg::REG_FRAME_WIDTH, b3mf_pkg::REG_W'(2));  // mid-frame
    write_reg(b3mf_pkg::REG_FRAME_HEIGHT, b3mf_pkg::REG_W'(2));
    send_beat(b3mf_pkg::CMD_PIXEL, 16'h8000);
    send_beat(b3mf_pkg::CMD_PIXEL, 16'h7fff);
    send_beat(b3mf_pkg::CMD_PIXEL, '1);
    send_beat(b3mf_pkg::CMD_PIXEL, '0);
    flush_frame('1, 1);
  endtask

  // start of a saturated-width row; the next register write cuts it off
  task automatic test_widest_row();
    write_reg(b3mf_pkg::REG_FRAME_WIDTH, '1);  // saturates
    write_reg(b3mf_pkg::REG_FRAME_HEIGHT, b3mf_pkg::REG_W'(1));
    stream_pixels(EDGE_BEATS);
    flush_frame('1, 1);
  endtask

  // top of a saturated-height column, one column wide
  task automatic test_tallest_column();
    write_reg(b3mf_pkg::REG_FRAME_WIDTH, b3mf_pkg::REG_W'(1));
    write_reg(b3mf_pkg::REG_FRAME_HEIGHT, '1);  // saturates
    stream_pixels(EDGE_BEATS);
    flush_frame('1, 1);
  endtask

  task automatic test_random_frames(int unsigned target);
    int unsigned n, style;
    useful_beats = 0;
    while (useful_beats < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if (random_frames == 0 || $urandom_range(0, 2) == 0)
        write_reg(b3mf_pkg::REG_FRAME_WIDTH, pick_size(8, 40));
      if (random_frames == 0 || $urandom_range(0, 2) == 0)
        write_reg(b3mf_pkg::REG_FRAME_HEIGHT, pick_size(6, 12));
      style = $urandom_range(0, 9);
      n = frame_cols() * frame_rows();
      if (style == 9) n = $urandom_range(1, n);  // cut short
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(b3mf_pkg::CMD_DRAIN, b3mf_pkg::DATA_W'($urandom));
        send_beat(b3mf_pkg::CMD_PIXEL, b3mf_pkg::DATA_W'($urandom));
        if (i == n / 2 && (random_frames == 0 || $urandom_range(0, 15) == 0))
          hold_until_drained();
      end
      if (style == 8) flush_frame($urandom_range(0, owed), 0);
      else if (style < 8) flush_frame('1, $urandom_range(0, 2));
      random_frames++;
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (4) begin
      write_reg(b3mf_pkg::REG_FRAME_WIDTH, b3mf_pkg::REG_W'($urandom_range(2, 6)));
      write_reg(b3mf_pkg::REG_FRAME_HEIGHT, b3mf_pkg::REG_W'($urandom_range(2, 5)));
      stream_pixels(frame_cols() * frame_rows());
      flush_frame('1, 0);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      m_ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 8);
      m_ready    = 1'b0;
    end else begin
      m_ready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    b3mf_pkg::res_t want;
    if (rst_n && m_valid && m_ready) begin
      results_seen++;
      if (means_due.size() == 0) begin
        $error("unexpected result beat: mean_out %0d frame_last %0b", m_data, m_last);
        errors++;
      end else begin
        want = means_due.pop_front();
        if (m_data !== want.mean) begin
          $error("mean_out: expected %0d, got %0d", want.mean, m_data);
          errors++;
        end
        if (m_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, m_last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_tready) || (m_valid && m_ready) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("box3x3_mean_filter_tb failed");
      $finish;
    end
  end

  initial begin
    foreach (row_above2[i]) row_above2[i] = '0;
    foreach (row_above1[i]) row_above1[i] = '0;
    foreach (win[c, r]) win[c][r] = '0;
    clear_frame();
    cfg_width  = b3mf_pkg::REG_W'(b3mf_pkg::RESET_WIDTH);
    cfg_height = b3mf_pkg::REG_W'(b3mf_pkg::RESET_HEIGHT);
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_degenerate_sizes();
    test_checkerboard_3x3();
    test_register_restart();
    test_widest_row();
    test_tallest_column();
    test_random_frames(RANDOM_BEATS);
    test_back_to_back();

    hold_until_drained();
    repeat (IDLE_GUARD) @(posedge clk);
    $display("covered degenerate sizes, a 3x3 frame, restarts, the start of 4096-wide and");
    $display("4096-tall frames and %0d random frames; %0d beats sent, %0d results checked",
             random_frames, beats_sent, results_seen);
    if (errors == 0) begin
      $display("box3x3_mean_filter_tb passed");
    end else begin
      $display("box3x3_mean_filter_tb failed");
    end
    $finish;
  end

endmodule
